FILE: rtl/ioiw_pkg.sv
// Shared types and constants for the in-order issue window.
package ioiw_pkg;

  localparam int TRACK_DEPTH = 256;
  localparam int TRACK_AW    = $clog2(TRACK_DEPTH);
  localparam int SEQ_W       = 16;
  localparam int SPAN_W      = 9;
  localparam int LIMIT_W     = 5;
  localparam int CNT_W       = 5;
  localparam int ACT_W       = 3;
  localparam int CFG_IDX_W   = 1;

  localparam int SPAN_RST  = 32;
  localparam int LIMIT_RST = 4;

  localparam logic [CNT_W-1:0]     CNT_MAX       = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPAN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_QUERY    = 3'd1,
    ACT_ISSUE    = 3'd2,
    ACT_COMPLETE = 3'd3,
    ACT_TICK     = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC_A,
    S_CALC_B,
    S_RET_RD,
    S_RET_CHK,
    S_END_A,
    S_END_B,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
    logic             inv_b;
    logic             cin;
  } alu_req_t;

  typedef struct packed {
    logic                we;
    logic [TRACK_AW-1:0] waddr;
    logic                wdata;
    logic                re;
    logic [TRACK_AW-1:0] raddr;
  } ram_req_t;

endpackage

FILE: rtl/ioiw_alu.sv
// Shared 16-bit add/subtract unit used by the sequencer.
module ioiw_alu import ioiw_pkg::*; (
  input  alu_req_t         req,
  output logic [SEQ_W-1:0] res
);

  logic [SEQ_W-1:0] b_eff;

  assign b_eff = req.inv_b ? ~req.b : req.b;
  assign res   = req.a + b_eff + {{(SEQ_W-1){1'b0}}, req.cin};

endmodule

FILE: rtl/ioiw_done_ram.sv
// Completion bit store: one write and one registered read per cycle.
module ioiw_done_ram import ioiw_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output logic     rdata
);

  logic mem [TRACK_DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/in_order_issue_window_top.sv
// Top level of the in-order issue window: sequencer, state and result register.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------------
//   in      | input     | in_valid, in_ready, in_action, in_seq
//   out     | output    | out_valid, out_ready, out_assigned_seq, out_may_issue,
//           |           | out_win_start, out_win_end, out_fault
//   cfg     | input     | cfg_we, cfg_index, cfg_wdata
//
// One beat at a time. Insert, query and complete go from accept through
// S_CALC_A and S_CALC_B on the shared adder to the result load in S_DONE;
// issue and unused codes go from S_CALC_A to S_DONE. A tick retires the run
// of done entries, one completion-bit read each (S_RET_RD, S_RET_CHK), up to
// an empty tracker or an entry not yet done, then updates the end if any retired.
// Synchronous active-low reset; the completion store needs no clearing pass.
// A stalled result holds the sequencer in its last step; in_ready stays low.
module in_order_issue_window_top import ioiw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [SEQ_W-1:0]     in_seq,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SEQ_W-1:0]     out_assigned_seq,
  output logic                 out_may_issue,
  output logic [SEQ_W-1:0]     out_win_start,
  output logic [SEQ_W-1:0]     out_win_end,
  output logic                 out_fault,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPAN_W-1:0]    cfg_wdata
);

  state_t               state_r, state_nxt;
  logic [SPAN_W-1:0]    span_r, span_nxt;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [SEQ_W-1:0]     next_r, next_nxt;
  logic [SEQ_W-1:0]     start_r, start_nxt;
  logic [SEQ_W-1:0]     end_r, end_nxt;
  logic [CNT_W-1:0]     issued_r, issued_nxt;
  logic                 moved_r, moved_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [ACT_W-1:0]     act_r, act_nxt;
  logic [SEQ_W-1:0]     seq_r, seq_nxt;
  logic [SEQ_W-1:0]     tmp_r, tmp_nxt;
  logic [SEQ_W-1:0]     res_assigned_r, res_assigned_nxt;
  logic                 res_may_r, res_may_nxt;
  logic                 res_fault_r, res_fault_nxt;
  logic [SEQ_W-1:0]     out_assigned_r, out_assigned_nxt;
  logic                 out_may_r, out_may_nxt;
  logic [SEQ_W-1:0]     out_start_r, out_start_nxt;
  logic [SEQ_W-1:0]     out_end_r, out_end_nxt;
  logic                 out_fault_r, out_fault_nxt;

  alu_req_t             alu_req;
  logic [SEQ_W-1:0]     alu_res;
  ram_req_t             ram_req;
  logic                 ram_rdata;

  ioiw_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  ioiw_done_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      span_r      <= SPAN_W'(SPAN_RST);
      limit_r     <= LIMIT_W'(LIMIT_RST);
      next_r      <= '0;
      start_r     <= '0;
      end_r       <= SEQ_W'(SPAN_RST - 1);
      issued_r    <= '0;
      moved_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      span_r      <= span_nxt;
      limit_r     <= limit_nxt;
      next_r      <= next_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      issued_r    <= issued_nxt;
      moved_r     <= moved_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r          <= act_nxt;
    seq_r          <= seq_nxt;
    tmp_r          <= tmp_nxt;
    res_assigned_r <= res_assigned_nxt;
    res_may_r      <= res_may_nxt;
    res_fault_r    <= res_fault_nxt;
    out_assigned_r <= out_assigned_nxt;
    out_may_r      <= out_may_nxt;
    out_start_r    <= out_start_nxt;
    out_end_r      <= out_end_nxt;
    out_fault_r    <= out_fault_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    span_nxt         = span_r;
    limit_nxt        = limit_r;
    next_nxt         = next_r;
    start_nxt        = start_r;
    end_nxt          = end_r;
    issued_nxt       = issued_r;
    moved_nxt        = moved_r;
    out_valid_nxt    = out_valid_r;
    act_nxt          = act_r;
    seq_nxt          = seq_r;
    tmp_nxt          = tmp_r;
    res_assigned_nxt = res_assigned_r;
    res_may_nxt      = res_may_r;
    res_fault_nxt    = res_fault_r;
    out_assigned_nxt = out_assigned_r;
    out_may_nxt      = out_may_r;
    out_start_nxt    = out_start_r;
    out_end_nxt      = out_end_r;
    out_fault_nxt    = out_fault_r;
    alu_req          = '0;
    ram_req          = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_SPAN:  span_nxt  = cfg_wdata;
        CFG_IDX_LIMIT: limit_nxt = cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt          = in_action;
          seq_nxt          = in_seq;
          res_assigned_nxt = '0;
          res_may_nxt      = 1'b0;
          res_fault_nxt    = 1'b0;
          moved_nxt        = 1'b0;
          state_nxt        = S_CALC_A;
        end
      end
      S_CALC_A: begin
        case (action_t'(act_r))
          ACT_INSERT, ACT_QUERY, ACT_COMPLETE: begin
            alu_req.a     = (action_t'(act_r) == ACT_INSERT) ? next_r : seq_r;
            alu_req.b     = start_r;
            alu_req.inv_b = 1'b1;
            alu_req.cin   = 1'b1;
            tmp_nxt       = alu_res;
            state_nxt     = S_CALC_B;
          end
          ACT_ISSUE: begin
            res_fault_nxt = (issued_r >= limit_r);
            if (issued_r != CNT_MAX) begin
              issued_nxt = issued_r + CNT_W'(1);
            end
            state_nxt = S_DONE;
          end
          ACT_TICK: begin
            issued_nxt = '0;
            state_nxt  = S_RET_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_CALC_B: begin
        case (action_t'(act_r))
          ACT_INSERT: begin
            // tmp holds occupancy
            if (tmp_r >= SEQ_W'(TRACK_DEPTH)) begin
              res_fault_nxt = 1'b1;
            end else begin
              res_assigned_nxt = next_r;
              ram_req.we       = 1'b1;
              ram_req.waddr    = next_r[TRACK_AW-1:0];
              ram_req.wdata    = 1'b0;
              alu_req.a        = next_r;
              alu_req.cin      = 1'b1;
              next_nxt         = alu_res;
            end
          end
          ACT_QUERY: begin
            alu_req.a     = end_r;
            alu_req.b     = start_r;
            alu_req.inv_b = 1'b1;
            alu_req.cin   = 1'b1;
            res_may_nxt   = (issued_r < limit_r) && (tmp_r <= alu_res);
          end
          ACT_COMPLETE: begin
            alu_req.a     = next_r;
            alu_req.b     = start_r;
            alu_req.inv_b = 1'b1;
            alu_req.cin   = 1'b1;
            if (tmp_r < alu_res) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = seq_r[TRACK_AW-1:0];
              ram_req.wdata = 1'b1;
            end
          end
          default: ;
        endcase
        state_nxt = S_DONE;
      end
      S_RET_RD: begin
        if (start_r == next_r) begin
          state_nxt = moved_r ? S_END_A : S_DONE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = start_r[TRACK_AW-1:0];
          state_nxt     = S_RET_CHK;
        end
      end
      S_RET_CHK: begin
        if (ram_rdata) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = start_r[TRACK_AW-1:0];
          ram_req.wdata = 1'b0;
          alu_req.a     = start_r;
          alu_req.cin   = 1'b1;
          start_nxt     = alu_res;
          moved_nxt     = 1'b1;
          state_nxt     = S_RET_RD;
        end else begin
          state_nxt = moved_r ? S_END_A : S_DONE;
        end
      end
      S_END_A: begin
        alu_req.a = start_r;
        alu_req.b = {{(SEQ_W-SPAN_W){1'b0}}, span_r};
        tmp_nxt   = alu_res;
        state_nxt = S_END_B;
      end
      S_END_B: begin
        // minus one
        alu_req.a = tmp_r;
        alu_req.b = '1;
        end_nxt   = alu_res;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_assigned_nxt = res_assigned_r;
          out_may_nxt      = res_may_r;
          out_start_nxt    = start_r;
          out_end_nxt      = end_r;
          out_fault_nxt    = res_fault_r;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_assigned_seq = out_assigned_r;
  assign out_may_issue    = out_may_r;
  assign out_win_start    = out_start_r;
  assign out_win_end      = out_end_r;
  assign out_fault        = out_fault_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (SEQ_W'(next_r - start_r) <= SEQ_W'(TRACK_DEPTH)))
    else $error("tracker occupancy exceeds depth");

  a_fault_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_fault_r && (out_assigned_r != '0)))
    else $error("faulted beat carries an assigned sequence");

  a_retire_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RET_CHK) |-> (start_r != next_r))
    else $error("retire check on empty tracker");

  a_retire_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RET_CHK && ram_rdata) |=> (start_r == SEQ_W'($past(start_r) + 1)))
    else $error("retire did not advance start by one");

endmodule

FILE: tb/in_order_issue_window_top_tb.sv
// Self-checking testbench for the in-order issue window: directed table, then random phases.
`timescale 1ns / 100ps

module in_order_issue_window_top_tb;
  import ioiw_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct {
    logic [SEQ_W-1:0] assigned_seq;
    logic             may_issue;
    logic [SEQ_W-1:0] win_start;
    logic [SEQ_W-1:0] win_end;
    logic             fault;
  } window_result_t;

  typedef struct {
    logic [ACT_W-1:0] act;
    logic [SEQ_W-1:0] seq;
    bit               typed;
    window_result_t   want;
  } dir_row_t;

  typedef struct {
    int span;
    int limit;
    int items;
    int ins;
    int cmp;
    int qry;
    int iss;
    int tck;
  } setting_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ACT_W-1:0]     in_action = '0;
  logic [SEQ_W-1:0]     in_seq = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SEQ_W-1:0]     out_assigned_seq;
  logic                 out_may_issue;
  logic [SEQ_W-1:0]     out_win_start;
  logic [SEQ_W-1:0]     out_win_end;
  logic                 out_fault;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SPAN_W-1:0]    cfg_wdata = '0;

  // window state as the block should hold it
  bit                   done_flag [TRACK_DEPTH];
  logic [SEQ_W-1:0]     seq_next = '0;
  logic [SEQ_W-1:0]     seq_start = '0;
  logic [SEQ_W-1:0]     seq_end = SEQ_W'(SPAN_RST - 1);
  logic [CNT_W-1:0]     issue_count = '0;
  logic [SPAN_W-1:0]    span_reg = SPAN_W'(SPAN_RST);
  logic [LIMIT_W-1:0]   limit_reg = LIMIT_W'(LIMIT_RST);

  window_result_t       window_results_due [$];
  dir_row_t             directed [$];
  setting_t             plan [$];
  int                   errors = 0;
  int                   beats = 0;
  int                   checked = 0;
  int                   faults_seen = 0;
  int                   full_rejects = 0;
  int                   retired = 0;
  bit                   no_idle = 1'b0;

  in_order_issue_window_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_seq           (in_seq),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_assigned_seq (out_assigned_seq),
    .out_may_issue    (out_may_issue),
    .out_win_start    (out_win_start),
    .out_win_end      (out_win_end),
    .out_fault        (out_fault),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // applies one beat to the window state and returns the result it should give
  function automatic window_result_t advance_window(input logic [ACT_W-1:0] act,
                                                    input logic [SEQ_W-1:0] s);
    window_result_t   r;
    logic [SEQ_W-1:0] occ;
    logic [SEQ_W-1:0] off;
    logic [SEQ_W-1:0] width;
    bit               moved;
    r = '{default: '0};
    occ = seq_next - seq_start;
    off = s - seq_start;
    width = seq_end - seq_start;
    moved = 1'b0;
    case (act)
      ACT_INSERT: begin
        if (occ >= TRACK_DEPTH) begin
          r.fault = 1'b1;
        end else begin
          r.assigned_seq = seq_next;
          done_flag[seq_next[TRACK_AW-1:0]] = 1'b0;
          seq_next = seq_next + 1'b1;
        end
      end
      ACT_QUERY: begin
        r.may_issue = (issue_count < limit_reg) && (off <= width);
      end
      ACT_ISSUE: begin
        r.fault = (issue_count >= limit_reg);
        if (issue_count != CNT_MAX) issue_count = issue_count + 1'b1;
      end
      ACT_COMPLETE: begin
        if (off < occ) done_flag[s[TRACK_AW-1:0]] = 1'b1;
      end
      ACT_TICK: begin
        issue_count = '0;
        while (seq_start != seq_next && done_flag[seq_start[TRACK_AW-1:0]]) begin
          done_flag[seq_start[TRACK_AW-1:0]] = 1'b0;
          seq_start = seq_start + 1'b1;
          moved = 1'b1;
          retired++;
        end
        if (moved) seq_end = seq_start + SEQ_W'(span_reg) - 1'b1;
      end
      default: ;
    endcase
    r.win_start = seq_start;
    r.win_end = seq_end;
    return r;
  endfunction

  task automatic send_beat(input logic [ACT_W-1:0] act, input logic [SEQ_W-1:0] s,
                           input bit typed, input window_result_t want);
    window_result_t r;
    int             gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_seq <= s;
    do @(posedge clk); while (!in_ready);
    r = advance_window(act, s);
    if (act == ACT_INSERT && r.fault) full_rejects++;
    window_results_due.insert(window_results_due.size(), typed ? want : r);
    beats++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPAN_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_SPAN) span_reg = val;
    else limit_reg = val[LIMIT_W-1:0];
  endtask

  function automatic void add_row(input logic [ACT_W-1:0] act, input logic [SEQ_W-1:0] s,
                                  input bit typed, input logic [SEQ_W-1:0] asg,
                                  input logic may, input logic [SEQ_W-1:0] ws,
                                  input logic [SEQ_W-1:0] we, input logic flt);
    dir_row_t d;
    d.act = act;
    d.seq = s;
    d.typed = typed;
    d.want = '{asg, may, ws, we, flt};
    directed.insert(directed.size(), d);
  endfunction

  function automatic void add_setting(input int span, input int limit, input int items,
                                      input int ins, input int cmp, input int qry,
                                      input int iss, input int tck);
    setting_t st;
    st = '{span, limit, items, ins, cmp, qry, iss, tck};
    plan.insert(plan.size(), st);
  endfunction

  // result sink: random stalls per beat, with bursts of none
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    window_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (window_results_due.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = window_results_due.pop_front();
        checked++;
        if (want.fault) faults_seen++;
        if (out_assigned_seq !== want.assigned_seq)
          report_mismatch($sformatf("assigned_seq %h, expected %h",
                                    out_assigned_seq, want.assigned_seq));
        if (out_may_issue !== want.may_issue)
          report_mismatch($sformatf("may_issue %b, expected %b", out_may_issue, want.may_issue));
        if (out_win_start !== want.win_start)
          report_mismatch($sformatf("win_start %h, expected %h", out_win_start, want.win_start));
        if (out_win_end !== want.win_end)
          report_mismatch($sformatf("win_end %h, expected %h", out_win_end, want.win_end));
        if (out_fault !== want.fault)
          report_mismatch($sformatf("fault %b, expected %b", out_fault, want.fault));
      end
    end
  end

  initial begin : stimulus
    setting_t         ph;
    window_result_t   none;
    logic [ACT_W-1:0] act;
    logic [SEQ_W-1:0] s;
    logic [SEQ_W-1:0] occ;
    logic [SEQ_W-1:0] wspan;
    int               pick;
    none = '{default: '0};

    //      action        seq         typed asg    may   start  end    fault
    add_row(ACT_TICK,     16'h0000, 1, 16'd0, 1'b0, 16'd0, 16'd31, 1'b0);
    add_row(ACT_QUERY,    16'h0000, 1, 16'd0, 1'b1, 16'd0, 16'd31, 1'b0);
    add_row(ACT_QUERY,    16'd31,   1, 16'd0, 1'b1, 16'd0, 16'd31, 1'b0);
    add_row(ACT_QUERY,    16'd32,   1, 16'd0, 1'b0, 16'd0, 16'd31, 1'b0);
    add_row(ACT_QUERY,    16'hFFFF, 1, 16'd0, 1'b0, 16'd0, 16'd31, 1'b0);
    add_row(ACT_INSERT,   16'hFFFF, 1, 16'd0, 1'b0, 16'd0, 16'd31, 1'b0);
    add_row(ACT_INSERT,   16'h0000, 1, 16'd1, 1'b0, 16'd0, 16'd31, 1'b0);
    add_row(ACT_INSERT,   16'h5555, 1, 16'd2, 1'b0, 16'd0, 16'd31, 1'b0);
    // complete of an untracked entry is dropped
    add_row(ACT_COMPLETE, 16'd3,    1, 16'd0, 1'b0, 16'd0, 16'd31, 1'b0);
    add_row(ACT_COMPLETE, 16'd1,    1, 16'd0, 1'b0, 16'd0, 16'd31, 1'b0);
    // oldest not done yet: no retirement
    add_row(ACT_TICK,     16'hAAAA, 1, 16'd0, 1'b0, 16'd0, 16'd31, 1'b0);
    add_row(ACT_COMPLETE, 16'd0,    1, 16'd0, 1'b0, 16'd0, 16'd31, 1'b0);
    add_row(ACT_TICK,     16'h0000, 0, 16'd0, 1'b0, 16'd0, 16'd0,  1'b0);
    repeat (5)
      add_row(ACT_ISSUE,  16'hFFFF, 0, 16'd0, 1'b0, 16'd0, 16'd0,  1'b0);
    add_row(ACT_QUERY,    16'd2,    0, 16'd0, 1'b0, 16'd0, 16'd0,  1'b0);
    add_row(ACT_SPARE_LO, 16'hFFFF, 0, 16'd0, 1'b0, 16'd0, 16'd0,  1'b0);
    add_row(ACT_SPARE_HI, 16'h5555, 0, 16'd0, 1'b0, 16'd0, 16'd0,  1'b0);
    add_row(ACT_TICK,     16'h0000, 0, 16'd0, 1'b0, 16'd0, 16'd0,  1'b0);
    add_row(ACT_QUERY,    16'd33,   0, 16'd0, 1'b0, 16'd0, 16'd0,  1'b0);
    add_row(ACT_QUERY,    16'd34,   0, 16'd0, 1'b0, 16'd0, 16'd0,  1'b0);

    //          span  limit items ins cmp qry iss tck
    add_setting(SPAN_RST, LIMIT_RST, 250, 30, 25, 20, 10, 10);
    add_setting(1,     1,  200, 55, 10, 15, 10,  8);
    add_setting(256,  16,  250, 70,  5, 10,  8,  5);
    add_setting(0,     0,  150, 10, 40, 20, 15, 12);
    add_setting(511,  31,  200, 10, 15, 25, 45,  2);
    repeat (4)
      add_setting($urandom_range(1, 256), $urandom_range(1, 16), 150,
                  25, 35, 15, 10, 12);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_beat(directed[i].act, directed[i].seq, directed[i].typed, directed[i].want);

    foreach (plan[p]) begin
      ph = plan[p];
      in_valid <= 1'b0;
      while (window_results_due.size() != 0) @(posedge clk);
      if (p > 0) begin
        write_reg(CFG_IDX_SPAN, SPAN_W'(ph.span));
        write_reg(CFG_IDX_LIMIT, SPAN_W'(ph.limit));
      end
      no_idle = (p % 3 == 2);
      repeat (ph.items) begin
        pick = $urandom_range(0, 99);
        if (pick < ph.ins) act = ACT_INSERT;
        else if (pick < ph.ins + ph.cmp) act = ACT_COMPLETE;
        else if (pick < ph.ins + ph.cmp + ph.qry) act = ACT_QUERY;
        else if (pick < ph.ins + ph.cmp + ph.qry + ph.iss) act = ACT_ISSUE;
        else if (pick < ph.ins + ph.cmp + ph.qry + ph.iss + ph.tck) act = ACT_TICK;
        else act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        s = SEQ_W'($urandom);
        occ = seq_next - seq_start;
        wspan = seq_end - seq_start;
        if (act == ACT_QUERY && $urandom_range(0, 9) < 7) begin
          // near the window edges
          s = seq_start + SEQ_W'($urandom_range(0, int'(wspan) + 8)) - 16'd4;
        end else if (act == ACT_COMPLETE && occ != 0 && $urandom_range(0, 9) < 8) begin
          // bias toward the oldest entries so runs retire
          if ($urandom_range(0, 9) < 4)
            s = seq_start + SEQ_W'($urandom_range(0, (occ > 4) ? 3 : int'(occ) - 1));
          else
            s = seq_start + SEQ_W'($urandom_range(0, int'(occ) - 1));
        end
        send_beat(act, s, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (window_results_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Issue window: %0d beats over %0d settings, %0d results checked, %0d errors.",
             beats, plan.size(), checked, errors);
    $display("Faults seen %0d (tracker full %0d), entries retired %0d.",
             faults_seen, full_rejects, retired);
    if (errors == 0 && window_results_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ioiw_pkg.sv
rtl/ioiw_alu.sv
rtl/ioiw_done_ram.sv
rtl/in_order_issue_window_top.sv
tb/in_order_issue_window_top_tb.sv
